// File: src/vlrc_pkg.sv
package vlrc_pkg;

	localparam int FRACTION_BITS_DEF = 32;
	localparam int SYSF_W   = 32;
	localparam int RATE_W   = 8;
	localparam int SPEED_W  = 18;
	localparam int TIME_W   = 64;
	localparam int MISS_W   = 32;
	localparam int COUNT_W  = 8;
	localparam int CFG_W    = 64;
	localparam int CFG_IDX_W = 3;
	localparam int CATCH_NUM = 13;
	localparam int CATCH_DEN = 10;
	// floor(x / 10) = (x * ceil(2^39 / 10)) >> 39 for any x below 2^36
	localparam int CATCH_SHIFT = 39;
	localparam logic [63:0] CATCH_RECIP = 64'd54975581389;

	localparam logic [SYSF_W-1:0]  SYSF_RST  = 32'd1000000000;
	localparam logic [RATE_W-1:0]  RATE_RST  = 8'd60;
	localparam logic [SPEED_W-1:0] SPEED_RST = 18'd65536;

	localparam logic OP_REPORT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYSF   = 3'd0,
		REG_RATE   = 3'd1,
		REG_SPEED  = 3'd2,
		REG_USE_VB = 3'd3,
		REG_OFFSET = 3'd4
	} reg_idx_t;

	typedef enum logic [4:0] {
		CMD_NONE    = 5'd0,
		CMD_LOAD    = 5'd1,
		CMD_DIV_P   = 5'd2,
		CMD_DIV_T   = 5'd3,
		CMD_SET_IV  = 5'd4,
		CMD_REPORT  = 5'd5,
		CMD_HOST    = 5'd6,
		CMD_DIV_K   = 5'd7,
		CMD_SET_K   = 5'd8,
		CMD_MUL_KP  = 5'd9,
		CMD_UPD_LV  = 5'd10,
		CMD_MUL_FK  = 5'd11,
		CMD_SET_ACC = 5'd12,
		CMD_MUL_IK  = 5'd13,
		CMD_UPD_CUR = 5'd14,
		CMD_RES_CUR = 5'd15,
		CMD_MUL_DS  = 5'd16,
		CMD_SET_E   = 5'd17,
		CMD_CAND    = 5'd18,
		CMD_PUSH    = 5'd19
	} cmd_t;

	typedef struct packed {
		logic dirty;
		logic op;
		logic use_vb;
		logic interp;
		logic adv;
		logic catch_up;
		logic div_done;
		logic mul_done;
	} status_t;

endpackage

// File: src/vlrc_div.sv
module vlrc_div #(
	parameter int DW = 82
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);
	localparam int CNT_W = $clog2(DW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      rem_q;
	logic [31:0]      dvs_q;
	logic [DW-1:0]    quo_q;
	logic [32:0]      r2;
	logic             ge;

	assign r2 = {rem_q, quo_q[DW-1]};
	assign ge = r2 >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(r2 - {1'b0, dvs_q}) : r2[31:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// File: src/vlrc_mul.sv
module vlrc_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] product,
	output logic         done
);
	logic         busy_q;
	logic         done_q;
	logic [5:0]   cnt_q;
	logic [63:0]  a_q;
	logic [127:0] p_q;
	logic [64:0]  sum;

	assign sum = {1'b0, p_q[127:64]} + (p_q[0] ? {1'b0, a_q} : 65'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add, multiplier bits enter at the bottom of the product word
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {64'd0, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[63:1]};
		end
	end

	assign product = p_q;
	assign done    = done_q;

endmodule

// File: src/vlrc_dp.sv
module vlrc_dp #(
	parameter int FRACTION_BITS = vlrc_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [vlrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vlrc_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              operation,
	input  logic [vlrc_pkg::COUNT_W-1:0]      vblank_count,
	input  logic [vlrc_pkg::TIME_W-1:0]       timestamp,
	input  logic                              interpolated,
	input  vlrc_pkg::cmd_t                    cmd,
	output vlrc_pkg::status_t                 stat,
	output logic [vlrc_pkg::TIME_W-1:0]       clock_time,
	output logic [vlrc_pkg::MISS_W-1:0]       total_missed
);
	import vlrc_pkg::*;

	localparam int FB   = FRACTION_BITS;
	localparam int DW   = SPEED_W + SYSF_W + FB;
	localparam int IP_W = DW - FB;

	logic [SYSF_W-1:0]  sysf_q;
	logic [RATE_W-1:0]  rate_q;
	logic [SPEED_W-1:0] speed_q;
	logic               use_vb_q;
	logic [63:0]        offset_q;
	logic               dirty_q;

	logic               op_q;
	logic [COUNT_W-1:0] count_q;
	logic [63:0]        ts_q;
	logic               interp_q;

	logic [31:0]        p_q;
	logic [32:0]        t_q;
	logic [IP_W-1:0]    ip_q;
	logic [FB-1:0]      fr_q;

	logic [63:0]        cur_q;
	logic [FB-1:0]      tf_q;
	logic [63:0]        lrt_q;
	logic [63:0]        lvb_q;
	logic [31:0]        pend_q;
	logic [31:0]        miss_q;

	logic [63:0]        k_q;
	logic [FB+63:0]     acc_q;
	logic [63:0]        e_q;
	logic [63:0]        res_q;
	logic [63:0]        clock_time_q;
	logic [31:0]        total_missed_q;

	logic [RATE_W-1:0]  eff_rate;
	logic [63:0]        d_now;
	logic [63:0]        mag;
	logic [35:0]        p13;
	logic [49:0]        sp_prod;
	logic               div_start;
	logic [DW-1:0]      div_dvd;
	logic [31:0]        div_dvs;
	logic [DW-1:0]      quo;
	logic               div_done;
	logic               mul_start;
	logic [63:0]        mul_a;
	logic [63:0]        mul_b;
	logic [127:0]       prd;
	logic               mul_done;
	logic [63:0]        k_new;
	logic [63:0]        cap;
	logic [63:0]        e_raw;
	logic               e_ovf;
	logic [63:0]        cand;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [63:0] b);
		logic [31:0] bs;
		logic [32:0] s;
		bs = (|b[63:32]) ? 32'hFFFF_FFFF : b[31:0];
		s  = {1'b0, a} + {1'b0, bs};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	assign eff_rate = (rate_q == '0) ? RATE_W'(1) : rate_q;
	assign d_now    = ts_q - lvb_q;
	assign mag      = d_now[63] ? (64'd0 - d_now) : d_now;
	assign p13      = {4'd0, quo[31:0]} * 36'(CATCH_NUM);
	assign sp_prod  = {32'd0, speed_q} * {18'd0, sysf_q};
	assign k_new    = quo[63:0] + 64'd1;
	assign cap      = (64'(ip_q) << 1) + 64'(fr_q[FB-1]);
	assign e_raw    = prd[79:16];
	assign e_ovf    = |prd[127:80];
	assign cand     = cur_q + e_q;

	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (cmd)
			CMD_DIV_P: begin
				div_start = 1'b1;
				div_dvd   = DW'(sysf_q);
				div_dvs   = 32'(eff_rate);
			end
			// interval divide, threshold by reciprocal multiply alongside
			CMD_DIV_T: begin
				div_start = 1'b1;
				div_dvd   = {sp_prod, {FB{1'b0}}};
				div_dvs   = {8'd0, eff_rate, 16'd0};
				mul_start = 1'b1;
				mul_a     = 64'(p13);
				mul_b     = CATCH_RECIP;
			end
			CMD_DIV_K: begin
				div_start = 1'b1;
				div_dvd   = DW'(d_now - 64'(t_q));
				div_dvs   = p_q;
			end
			CMD_MUL_KP: begin
				mul_start = 1'b1;
				mul_a     = k_q;
				mul_b     = 64'(p_q);
			end
			CMD_MUL_FK: begin
				mul_start = 1'b1;
				mul_a     = 64'(fr_q);
				mul_b     = k_q;
			end
			CMD_MUL_IK: begin
				mul_start = 1'b1;
				mul_a     = 64'(ip_q);
				mul_b     = k_q;
			end
			CMD_MUL_DS: begin
				mul_start = 1'b1;
				mul_a     = mag;
				mul_b     = 64'(speed_q);
			end
			default: begin
			end
		endcase
	end

	vlrc_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (quo),
		.done     (div_done)
	);

	vlrc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.product (prd),
		.done    (mul_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sysf_q   <= SYSF_RST;
			rate_q   <= RATE_RST;
			speed_q  <= SPEED_RST;
			use_vb_q <= 1'b0;
			offset_q <= '0;
			dirty_q  <= 1'b1;
			cur_q    <= '0;
			tf_q     <= '0;
			lrt_q    <= '0;
			lvb_q    <= '0;
			pend_q   <= '0;
			miss_q   <= '0;
		end else begin
			if (cfg_write) begin
				dirty_q <= 1'b1;
				case (cfg_index)
					REG_SYSF:   sysf_q   <= cfg_data[SYSF_W-1:0];
					REG_RATE:   rate_q   <= cfg_data[RATE_W-1:0];
					REG_SPEED:  speed_q  <= cfg_data[SPEED_W-1:0];
					REG_USE_VB: use_vb_q <= cfg_data[0];
					REG_OFFSET: offset_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (cmd)
				CMD_SET_IV: dirty_q <= 1'b0;
				CMD_REPORT: begin
					lvb_q  <= ts_q;
					pend_q <= '0;
				end
				CMD_SET_K: begin
					pend_q <= sat_add(pend_q, k_new);
					miss_q <= sat_add(miss_q, k_new);
				end
				CMD_UPD_LV: lvb_q <= lvb_q + prd[63:0];
				CMD_UPD_CUR: begin
					cur_q <= cur_q + prd[63:0] + acc_q[FB+63:FB];
					tf_q  <= acc_q[FB-1:0];
				end
				CMD_CAND: begin
					if ($signed(cand) > $signed(lrt_q))
						lrt_q <= cand;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q     <= operation;
				count_q  <= vblank_count;
				ts_q     <= timestamp;
				interp_q <= interpolated;
			end
			CMD_DIV_T:  p_q <= quo[31:0];
			CMD_SET_IV: begin
				ip_q <= quo[DW-1:FB];
				fr_q <= quo[FB-1:0];
				t_q  <= prd[CATCH_SHIFT+32:CATCH_SHIFT];
			end
			CMD_REPORT: k_q <= 64'({24'd0, count_q} - pend_q);
			CMD_HOST:   res_q <= ts_q + offset_q;
			CMD_SET_K:  k_q <= k_new;
			// fold the carried fraction into the fractional product
			CMD_SET_ACC: acc_q <= prd[FB+63:0] + (FB+64)'(tf_q);
			CMD_RES_CUR: res_q <= cur_q;
			CMD_SET_E: begin
				if (d_now[63])
					e_q <= 64'd0 - e_raw;
				else if (e_ovf || e_raw > cap)
					e_q <= cap;
				else
					e_q <= e_raw;
			end
			CMD_CAND: res_q <= ($signed(cand) > $signed(lrt_q)) ? cand : lrt_q;
			CMD_PUSH: begin
				clock_time_q   <= res_q;
				total_missed_q <= miss_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.dirty    = dirty_q;
		stat.op       = op_q;
		stat.use_vb   = use_vb_q;
		stat.interp   = interp_q;
		stat.adv      = {24'd0, count_q} > pend_q;
		stat.catch_up = (p_q != '0) && !d_now[63] && (d_now >= 64'(t_q));
		stat.div_done = div_done;
		stat.mul_done = mul_done;
	end

	assign clock_time   = clock_time_q;
	assign total_missed = total_missed_q;

endmodule

// File: src/vlrc_ctrl.sv
module vlrc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  vlrc_pkg::status_t stat,
	output vlrc_pkg::cmd_t    cmd
);
	import vlrc_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE = 16'b0000000000000001,
		S_PREP = 16'b0000000000000010,
		S_W_P  = 16'b0000000000000100,
		S_W_IV = 16'b0000000000001000,
		S_DISP = 16'b0000000000010000,
		S_W_K  = 16'b0000000000100000,
		S_KP   = 16'b0000000001000000,
		S_W_KP = 16'b0000000010000000,
		S_ADV  = 16'b0000000100000000,
		S_W_FK = 16'b0000001000000000,
		S_IK   = 16'b0000010000000000,
		S_W_IK = 16'b0000100000000000,
		S_POST = 16'b0001000000000000,
		S_W_DS = 16'b0010000000000000,
		S_CAND = 16'b0100000000000000,
		S_OUT  = 16'b1000000000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (stat.dirty) begin
					cmd     = CMD_DIV_P;
					state_d = S_W_P;
				end else begin
					state_d = S_DISP;
				end
			end
			S_W_P: begin
				if (stat.div_done) begin
					cmd     = CMD_DIV_T;
					state_d = S_W_IV;
				end
			end
			// the threshold multiply finishes well before the interval divide
			S_W_IV: begin
				if (stat.div_done) begin
					cmd     = CMD_SET_IV;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.op == OP_REPORT) begin
					cmd     = CMD_REPORT;
					state_d = stat.adv ? S_ADV : S_POST;
				end else if (!stat.use_vb) begin
					cmd     = CMD_HOST;
					state_d = S_OUT;
				end else if (stat.catch_up) begin
					cmd     = CMD_DIV_K;
					state_d = S_W_K;
				end else begin
					state_d = S_POST;
				end
			end
			S_W_K: begin
				if (stat.div_done) begin
					cmd     = CMD_SET_K;
					state_d = S_KP;
				end
			end
			S_KP: begin
				cmd     = CMD_MUL_KP;
				state_d = S_W_KP;
			end
			S_W_KP: begin
				if (stat.mul_done) begin
					cmd     = CMD_UPD_LV;
					state_d = S_ADV;
				end
			end
			S_ADV: begin
				cmd     = CMD_MUL_FK;
				state_d = S_W_FK;
			end
			S_W_FK: begin
				if (stat.mul_done) begin
					cmd     = CMD_SET_ACC;
					state_d = S_IK;
				end
			end
			S_IK: begin
				cmd     = CMD_MUL_IK;
				state_d = S_W_IK;
			end
			S_W_IK: begin
				if (stat.mul_done) begin
					cmd     = CMD_UPD_CUR;
					state_d = S_POST;
				end
			end
			S_POST: begin
				if (stat.op == OP_QUERY && stat.interp) begin
					cmd     = CMD_MUL_DS;
					state_d = S_W_DS;
				end else begin
					cmd     = CMD_RES_CUR;
					state_d = S_OUT;
				end
			end
			S_W_DS: begin
				if (stat.mul_done) begin
					cmd     = CMD_SET_E;
					state_d = S_CAND;
				end
			end
			S_CAND: begin
				cmd     = CMD_CAND;
				state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the previous word has gone
				if (!out_valid_q || out_ready) begin
					cmd     = CMD_PUSH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd == CMD_PUSH)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_PUSH |=> out_valid)
		else $error("result word not presented after push");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == S_W_P || state_q == S_W_IV || state_q == S_W_K))
		else $error("divider finished outside a divide wait");

	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mul_done |-> (state_q == S_W_IV || state_q == S_W_KP ||
			state_q == S_W_FK || state_q == S_W_IK || state_q == S_W_DS))
		else $error("multiplier finished outside a multiply wait");

endmodule

// File: src/vblank_locked_reference_clock_top.sv
// Path from input word to result word: a report without advance runs no multiply;
// a report with advance runs two 64-step multiplies; a query with catch-up adds a
// (50+FRACTION_BITS)-step divide and three 64-step multiplies; interpolation adds
// one more multiply. After a register write the next item first rebuilds period,
// threshold and interval with two (50+FRACTION_BITS)-step divides.
// One item at a time. Reset: registers to defaults, clock state zero.
module vblank_locked_reference_clock_top #(
	parameter int FRACTION_BITS = vlrc_pkg::FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [vlrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vlrc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [vlrc_pkg::COUNT_W-1:0]   vblank_count,
	input  logic [vlrc_pkg::TIME_W-1:0]    timestamp,
	input  logic                           interpolated,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [vlrc_pkg::TIME_W-1:0]    clock_time,
	output logic [vlrc_pkg::MISS_W-1:0]    total_missed
);
	import vlrc_pkg::*;

	cmd_t    cmd;
	status_t stat;

	vlrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vlrc_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.vblank_count (vblank_count),
		.timestamp    (timestamp),
		.interpolated (interpolated),
		.cmd          (cmd),
		.stat         (stat),
		.clock_time   (clock_time),
		.total_missed (total_missed)
	);

endmodule

// File: dv/vlrc_checker.sv
`timescale 1ns / 1ps

module vlrc_checker
	import vlrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 operation,
	input  logic [COUNT_W-1:0]   vblank_count,
	input  logic [TIME_W-1:0]    timestamp,
	input  logic                 interpolated,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [TIME_W-1:0]    clock_time,
	input  logic [MISS_W-1:0]    total_missed,
	output int                   fail_count,
	output int                   outstanding
);

	typedef struct packed {
		logic [TIME_W-1:0] clk_time;
		logic [MISS_W-1:0] missed;
	} clock_word_t;

	clock_word_t clock_expect[$];

	logic [SYSF_W-1:0]  sysf;
	logic [RATE_W-1:0]  rate;
	logic [SPEED_W-1:0] speed;
	logic               use_vb;
	logic [TIME_W-1:0]  offset;

	logic [63:0] cur_t, frac_t, last_ret, last_vb;
	logic [31:0] pend_miss, miss_tot;

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [63:0] b);
		logic [32:0] s;
		s = {1'b0, a} + ((b > 64'hFFFF_FFFF) ? 33'h0_FFFF_FFFF : {1'b0, b[31:0]});
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// interval = ip + fr / 2^32, exact floor of speed * sysf / (rate * 2^16)
	task automatic get_interval(output logic [63:0] ip, output logic [63:0] fr);
		logic [127:0] prod, den, rem, q;
		prod = 128'(speed) * 128'(sysf);
		den = {104'd0, (rate == 0) ? 8'd1 : rate, 16'd0};
		q = prod / den;
		ip = q[63:0];
		rem = prod % den;
		q = (rem << 32) / den;
		fr = q[63:0];
	endtask

	task automatic advance_clock(logic [63:0] k);
		logic [63:0] ip, fr;
		logic [127:0] s;
		get_interval(ip, fr);
		s = 128'(k) * 128'(fr) + 128'(frac_t);
		cur_t = cur_t + ip * k + s[95:32];
		frac_t = {32'd0, s[31:0]};
	endtask

	task automatic predict_clock(logic op, logic [7:0] cnt, logic [63:0] now, logic interp);
		logic [63:0] p, t, d, k, ip, fr, cap, e, cand, mag, res;
		logic [127:0] m;
		logic neg;
		if (op == OP_REPORT) begin
			last_vb = now;
			if ({24'd0, cnt} > pend_miss)
				advance_clock(64'({24'd0, cnt} - pend_miss));
			pend_miss = 0;
			res = cur_t;
		end else if (!use_vb) begin
			res = now + offset;
		end else begin
			p = 64'(sysf) / 64'((rate == 0) ? 8'd1 : rate);
			t = p * CATCH_NUM / CATCH_DEN;
			d = now - last_vb;
			if (p != 0 && !d[63] && d >= t) begin
				k = (d - t) / p + 1;
				pend_miss = sat_add(pend_miss, k);
				miss_tot = sat_add(miss_tot, k);
				last_vb = last_vb + k * p;
				advance_clock(k);
			end
			if (interp) begin
				get_interval(ip, fr);
				cap = 2 * ip + ((2 * fr) >> 32);
				d = now - last_vb;
				neg = d[63];
				mag = neg ? -d : d;
				m = 128'(mag) * 128'(speed);
				e = m[79:16];
				if (neg)
					e = -e;
				else if (m[127:80] != 0 || e > cap)
					e = cap;
				cand = cur_t + e;
				if ($signed(cand) > $signed(last_ret))
					last_ret = cand;
				res = last_ret;
			end else begin
				res = cur_t;
			end
		end
		clock_expect.push_back('{res, miss_tot});
	endtask

	always @(posedge clk or negedge arst_n) begin
		clock_word_t w;
		if (!arst_n) begin
			sysf <= SYSF_RST;
			rate <= RATE_RST;
			speed <= SPEED_RST;
			use_vb <= 1'b0;
			offset <= '0;
			cur_t = 0;
			frac_t = 0;
			last_ret = 0;
			last_vb = 0;
			pend_miss = 0;
			miss_tot = 0;
			fail_count <= 0;
			clock_expect.delete();
		end else begin
			if (cfg_write) begin
				case (reg_idx_t'(cfg_index))
					REG_SYSF:   sysf <= cfg_data[SYSF_W-1:0];
					REG_RATE:   rate <= cfg_data[RATE_W-1:0];
					REG_SPEED:  speed <= cfg_data[SPEED_W-1:0];
					REG_USE_VB: use_vb <= cfg_data[0];
					REG_OFFSET: offset <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_clock(operation, vblank_count, timestamp, interpolated);
			if (out_valid && out_ready) begin
				if (clock_expect.size() == 0) begin
					$display("%0t: unexpected word clock_time=%h total_missed=%h",
						$time, clock_time, total_missed);
					fail_count <= fail_count + 1;
				end else begin
					w = clock_expect.pop_front();
					if (w.clk_time !== clock_time || w.missed !== total_missed) begin
						$display("%0t: expected clock_time=%h total_missed=%h, got %h %h",
							$time, w.clk_time, w.missed, clock_time, total_missed);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
		outstanding <= clock_expect.size();
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import vlrc_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int SETTLE = 700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = OP_REPORT;
	logic [COUNT_W-1:0] vblank_count = '0;
	logic [TIME_W-1:0] timestamp = '0;
	logic interpolated = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [TIME_W-1:0] clock_time;
	logic [MISS_W-1:0] total_missed;
	int fail_count, outstanding;

	int idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
	int hold_seq = 0;
	logic [63:0] host_t, period;

	always #10 clk = ~clk;

	vblank_locked_reference_clock_top dut (.*);

	vlrc_checker chk (.*);

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_cnt, seen;
		hold_cnt = 0;
		seen = 0;
		forever begin
			@(negedge clk);
			if (hold_seq != seen) begin
				seen = hold_seq;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (idle_mode >= 2)
				out_ready <= ($urandom_range(99) >= ((idle_mode == 3) ? 28 : 75));
			else
				out_ready <= 1'b1;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else if (++quiet >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0 || chk.clock_expect.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic configure(logic [31:0] f, logic [7:0] r, logic [17:0] s, logic v,
		logic [63:0] o);
		drain();
		write_reg(REG_SYSF, f);
		write_reg(REG_RATE, r);
		write_reg(REG_SPEED, s);
		write_reg(REG_USE_VB, v);
		write_reg(REG_OFFSET, o);
		period = f / ((r == 0) ? 1 : r);
		if (period == 0) period = 1;
	endtask

	task automatic send_word(logic op, logic [7:0] cnt, logic [63:0] ts, logic interp);
		int idle_pct;
		idle_pct = (idle_mode == 1) ? 75 : (idle_mode == 3) ? 28 : 0;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		vblank_count <= cnt;
		timestamp <= ts;
		interpolated <= interp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] upto(logic [63:0] lim);
		return rnd64() % (lim + 1);
	endfunction

	// mostly plausible frame timing, some noise
	task automatic random_word();
		logic [7:0] cnt;
		int sel;
		sel = $urandom_range(99);
		if (sel < 8) begin
			send_word($urandom_range(1), $urandom_range(255), rnd64(), $urandom_range(1));
		end else if (sel < 45) begin
			cnt = $urandom_range(0, 3);
			host_t = host_t + cnt * period + upto(period / 4) - period / 8;
			send_word(OP_REPORT, cnt, host_t, $urandom_range(1));
		end else begin
			send_word(OP_QUERY, $urandom_range(255), host_t + upto(4 * period) - period / 4,
				$urandom_range(1));
		end
	endtask

	task automatic random_phase(int n, int mode);
		idle_mode = mode;
		for (int i = 0; i < n; i++) begin
			if (i == n / 3 && mode == 0) hold_seq++;
			if (i == n / 2) drain();
			random_word();
		end
	endtask

	initial begin
		idle_mode = 0;
		host_t = 0;
		period = 64'd16666666;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// host mode at reset defaults
		send_word(OP_QUERY, 8'd0, 64'd1234, 1'b0);
		send_word(OP_REPORT, 8'd2, 64'd100, 1'b0);
		configure(32'd1000000000, 8'd60, 18'd65536, 1'b1, 64'd0);
		send_word(OP_REPORT, 8'd0, 64'd0, 1'b0);
		send_word(OP_REPORT, 8'd255, 64'd1000, 1'b1);
		send_word(OP_QUERY, 8'd0, 64'd1000, 1'b0);
		send_word(OP_QUERY, 8'd0, 64'd5000000, 1'b1);
		send_word(OP_QUERY, 8'd0, 64'd900, 1'b1);
		send_word(OP_QUERY, 8'hFF, 64'd100000000, 1'b1);
		send_word(OP_REPORT, 8'd1, 64'd100000001, 1'b0);
		send_word(OP_QUERY, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		send_word(OP_QUERY, 8'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
		send_word(OP_REPORT, 8'd3, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
		send_word(OP_QUERY, 8'd0, 64'd10, 1'b1);
		configure(32'd1, 8'd255, 18'd1, 1'b1, 64'd0);
		send_word(OP_REPORT, 8'd7, 64'd5, 1'b1);
		send_word(OP_QUERY, 8'd0, 64'd1000, 1'b1);
		configure(32'hFFFF_FFFF, 8'd1, 18'h3FFFF, 1'b1, 64'd0);
		send_word(OP_REPORT, 8'd255, 64'd0, 1'b0);
		send_word(OP_QUERY, 8'd0, 64'h0000_0010_0000_0000, 1'b1);
		configure(32'd1000, 8'd50, 18'd0, 1'b0, 64'h8000_0000_0000_0000);
		send_word(OP_QUERY, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		send_word(OP_REPORT, 8'd5, 64'd1, 1'b1);

		host_t = 0;
		configure(32'd1000000000, 8'd60, 18'd65536, 1'b1, 64'd0);
		random_phase(260, 0);
		configure(32'd90000, 8'd24, 18'd70000, 1'b1, 64'd0);
		random_phase(260, 1);
		configure(32'hFFFF_FFFF, 8'd1, 18'h3FFFF, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
		random_phase(240, 2);
		configure(32'd3, 8'd255, 18'd12345, 1'b1, 64'd0);
		random_phase(200, 3);
		configure(32'd48000, 8'd0, 18'd0, 1'b1, 64'd0);
		random_phase(200, 0);
		configure(32'd27000000, 8'd144, 18'd32768, 1'b0, 64'h8000_0000_0000_0000);
		random_phase(200, 1);
		configure($urandom, $urandom_range(1, 255), $urandom_range(0, 262143), 1'b1, rnd64());
		random_phase(300, 3);
		configure(32'd1, 8'd1, 18'd65536, 1'b1, 64'd0);
		random_phase(280, 2);

		drain();
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
